>>> design/rma_pkg.sv
// shared constants, types and helpers of the running mean accumulator
`default_nettype none

package rma_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COUNT_WIDTH  = 32;
  localparam int ITER_WIDTH   = $clog2(SAMPLE_WIDTH + 1);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX_UNSIGNED = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX_SIGNED   = {1'b0, {(COUNT_WIDTH-1){1'b1}}};

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // 32-bit raw sample to working width, zero or sign extended per mode
  function automatic logic [SAMPLE_WIDTH-1:0] extend_in(input logic [31:0] raw,
                                                         input logic sgn);
    logic [95:0] wide;
    wide = {{64{sgn & raw[31]}}, raw};
    return wide[SAMPLE_WIDTH-1:0];
  endfunction

  // working width value to the 32-bit output field, extended per mode
  function automatic logic [31:0] extend_out(input logic [SAMPLE_WIDTH-1:0] x,
                                             input logic sgn);
    logic [SAMPLE_WIDTH+31:0] wide;
    wide = {{32{sgn & x[SAMPLE_WIDTH-1]}}, x};
    return wide[31:0];
  endfunction

endpackage

`default_nettype wire

>>> design/rma_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rma_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [rma_pkg::SAMPLE_WIDTH-1:0]    dividend,
  input  wire logic [rma_pkg::COUNT_WIDTH-1:0]     divisor,
  output logic [rma_pkg::SAMPLE_WIDTH-1:0]         quotient,
  output rma_pkg::div_stat_t                       stat
);

  logic [rma_pkg::COUNT_WIDTH-1:0]  rem;
  logic [rma_pkg::COUNT_WIDTH-1:0]  dvs;
  logic [rma_pkg::SAMPLE_WIDTH-1:0] dvd;
  logic [rma_pkg::SAMPLE_WIDTH-1:0] quo;
  logic [rma_pkg::ITER_WIDTH-1:0]   iter;
  logic                             busy;
  logic                             done;

  logic [rma_pkg::COUNT_WIDTH:0] rem_sh;
  logic [rma_pkg::COUNT_WIDTH:0] rem_sub;
  logic                          fits;

  // shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh  = {rem, dvd[rma_pkg::SAMPLE_WIDTH-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= rma_pkg::ITER_WIDTH'(rma_pkg::SAMPLE_WIDTH);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == rma_pkg::ITER_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dvd <= dividend;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sub[rma_pkg::COUNT_WIDTH-1:0] : rem_sh[rma_pkg::COUNT_WIDTH-1:0];
      dvd <= {dvd[rma_pkg::SAMPLE_WIDTH-2:0], 1'b0};
      quo <= {quo[rma_pkg::SAMPLE_WIDTH-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

>>> design/running_mean_accumulator.sv
// top level of the running mean accumulator
`default_nettype none

// running mean accumulator: each request carries one 32-bit sample (tdata) and
// a restart flag (tuser). the block keeps a wrapping running sum and a
// saturating sample count, and returns the truncated mean of all samples so
// far together with the count. signed_mode is to be written on the cfg channel
// only while the block is idle (the block does not enforce this); it picks
// unsigned or two's-complement arithmetic; signed quotients round toward zero.
// the first sample after reset, or one with restart set, reloads the history
// and is returned as its own mean, through the hold state to the output
// register. every other request goes through a shared restoring divider that
// produces one quotient bit per cycle, through the load, divide and hold
// states to the output register. s_tready is low while a request is in
// progress; the finished result sits in the output register, and the next
// request is accepted while it waits to be taken.

module running_mean_accumulator (
  input  wire logic        clk,
  input  wire logic        rst,
  // sample request
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  input  wire logic        s_tuser,   // [0] restart
  // result
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] average, [63:32] samples_seen
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data   // [0] signed_mode
);

  localparam int W  = rma_pkg::SAMPLE_WIDTH;
  localparam int CW = rma_pkg::COUNT_WIDTH;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] ST_LOAD = 2'd1;  // sum and count updated, start divide
  localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
  localparam logic [1:0] ST_HOLD = 2'd3;  // result waits for the output register

  logic [1:0]    state;
  logic          signed_mode;
  logic [W-1:0]  running_sum;
  logic [CW-1:0] sample_count;
  logic          sum_neg;     // sign of the sum being divided
  logic [W-1:0]  res_avg;

  logic          in_fire;
  logic          out_free;
  logic [W-1:0]  smp;
  logic [CW-1:0] cap;
  logic [CW-1:0] count_next;
  logic          div_neg;
  logic [W-1:0]  div_dvd;
  logic [W-1:0]  div_quo;
  logic          div_start;
  rma_pkg::div_stat_t div_stat;

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // sample at working width
  assign smp = rma_pkg::extend_in(s_tdata, signed_mode);

  // count saturates at the largest positive count of the mode
  always_comb begin
    cap        = signed_mode ? rma_pkg::CNT_MAX_SIGNED : rma_pkg::CNT_MAX_UNSIGNED;
    count_next = (sample_count >= cap) ? cap : sample_count + 1'b1;
  end

  // divide the magnitude, put the sign back afterwards
  assign div_start = (state == ST_LOAD);
  assign div_neg   = signed_mode && running_sum[W-1];
  assign div_dvd   = div_neg ? (~running_sum + 1'b1) : running_sum;

  rma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (sample_count),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      signed_mode <= cfg_data;
    end
  end

  // sequencer and history
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_sum  <= '0;
      sample_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_tuser || sample_count == '0) begin
              // fresh history: the sample is its own mean
              running_sum  <= smp;
              sample_count <= CW'(1);
              state        <= ST_HOLD;
            end else begin
              running_sum  <= running_sum + smp;
              sample_count <= count_next;
              state        <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      res_avg <= smp;
    end else if (state == ST_DIV && div_stat.done) begin
      res_avg <= sum_neg ? (~div_quo + 1'b1) : div_quo;
    end
    if (state == ST_LOAD) begin
      sum_neg <= div_neg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      m_tdata <= {sample_count, rma_pkg::extend_out(res_avg, signed_mode)};
    end
  end

  // the divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_DIV))
    else $error("divider busy outside the divide state");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  // history is never empty after a request
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (sample_count != '0))
    else $error("sample count zero after a request");

  // a started divide leaves the load state at once
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_DIV) && div_stat.busy)
    else $error("divider did not start from the load state");

endmodule

`default_nettype wire
